FILE: rtl/icf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_pkg
// Shared types, constants and the header template of the APP2 segment framer.
// ----------------------------------------------------------------------------
package icf_pkg;

    localparam int LEN_W = 31;

    localparam logic [16:0] SEGMENT_PAYLOAD = 17'd65519;
    localparam int          HEADER_BYTES    = 18;
    localparam logic [30:0] FIRST_EXTRA     = 31'd38;
    localparam logic [16:0] FIRST_SEG_BYTES = 17'd65557;
    localparam logic [31:0] PROFILE_BYTES   = 32'd901;
    localparam logic [16:0] WARN_SEGMENTS   = 17'd100;
    localparam logic [30:0] RESET_LENGTH    = 31'd1024;
    localparam logic [31:0] RESET_SIZE      = 32'd123;  // reset length less profile bytes
    localparam logic [15:0] SEG_LEN_EXTRA   = 16'd16;

    // input positions that are patched
    localparam logic [30:0] POS_SEG_HI  = 31'h16;
    localparam logic [30:0] POS_SEG_LO  = 31'h17;
    localparam logic [30:0] POS_TOTAL   = 31'h25;
    localparam logic [30:0] POS_PROF_HI = 31'h28;
    localparam logic [30:0] POS_PROF_LO = 31'h29;
    localparam logic [30:0] POS_SIZE_B3 = 31'h203;
    localparam logic [30:0] POS_SIZE_B2 = 31'h204;
    localparam logic [30:0] POS_SIZE_B1 = 31'h205;
    localparam logic [30:0] POS_SIZE_B0 = 31'h206;
    localparam logic [30:0] POS_CNT_HI  = 31'h207;
    localparam logic [30:0] POS_CNT_LO  = 31'h208;

    localparam logic [4:0] HDR_LAST_IDX = 5'(HEADER_BYTES - 1);

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_FOLD,
        DRV_REFOLD,
        DRV_FIN
    } t_drv_state;

    // derived stream settings, valid whenever busy is low
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             single;
        logic [15:0]      seg_count;
        logic [31:0]      size_field;
        logic             warn;
        logic             busy;
    } t_derived;

    // one byte of the 18-byte header of a later segment
    function automatic logic [7:0] hdr_byte(input logic [4:0] idx,
                                            input logic [15:0] seg_len,
                                            input logic [15:0] seg_num);
        logic [7:0] v;
        unique case (idx)
            5'd0:    v = 8'hFF;
            5'd1:    v = 8'hE2;
            5'd2:    v = seg_len[15:8];
            5'd3:    v = seg_len[7:0];
            5'd4:    v = 8'h49;  // I
            5'd5:    v = 8'h43;  // C
            5'd6:    v = 8'h43;  // C
            5'd7:    v = 8'h5F;  // _
            5'd8:    v = 8'h50;  // P
            5'd9:    v = 8'h52;  // R
            5'd10:   v = 8'h4F;  // O
            5'd11:   v = 8'h46;  // F
            5'd12:   v = 8'h49;  // I
            5'd13:   v = 8'h4C;  // L
            5'd14:   v = 8'h45;  // E
            5'd15:   v = seg_num[15:8];
            5'd16:   v = seg_num[7:0];
            5'd17:   v = 8'hFF;
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/icf_derive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icf_derive
// Holds the stream length and works out the segment count, size field and
// warning flag after a write, dividing by the payload size in three steps.
// ----------------------------------------------------------------------------
module icf_derive (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_fire,
    input  logic [icf_pkg::LEN_W-1:0]     i_cfg_len,
    output icf_pkg::t_derived             o_drv
);

    icf_pkg::t_drv_state r_state, n_state;

    logic [icf_pkg::LEN_W-1:0] r_len, n_len;
    logic                      r_single, n_single;
    logic [15:0]               r_count, n_count;
    logic [31:0]               r_size, n_size;
    logic                      r_warn, n_warn;
    logic [15:0]               r_quo, n_quo;
    logic [20:0]               r_rem, n_rem;

    logic [icf_pkg::LEN_W-1:0] n_data;
    logic [14:0]               data_hi;
    logic [20:0]               fold1;
    logic [4:0]                rem_hi;
    logic [16:0]               fold2;
    logic [16:0]               fold2_sub;
    logic                      fold2_ge;
    logic [16:0]               segs;
    logic [31:0]               segs_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= icf_pkg::DRV_IDLE;
            r_len    <= icf_pkg::RESET_LENGTH;
            r_single <= 1'b1;
            r_count  <= '0;
            r_size   <= icf_pkg::RESET_SIZE;
            r_warn   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_single <= n_single;
            r_count  <= n_count;
            r_size   <= n_size;
            r_warn   <= n_warn;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    // payload is 2^16 - 17: fold the high part back in as 17 times itself
    assign n_data    = r_len - icf_pkg::FIRST_EXTRA;
    assign data_hi   = n_data[30:16];
    assign fold1     = {5'd0, n_data[15:0]} + {2'd0, data_hi, 4'd0} + {6'd0, data_hi};
    assign rem_hi    = r_rem[20:16];
    assign fold2     = {1'b0, r_rem[15:0]} + {8'd0, rem_hi, 4'd0} + {12'd0, rem_hi};
    assign fold2_ge  = fold2 >= icf_pkg::SEGMENT_PAYLOAD;
    assign fold2_sub = fold2 - icf_pkg::SEGMENT_PAYLOAD;
    assign segs      = {1'b0, r_quo} + {16'd0, (r_rem != 21'd0)};
    assign segs_m1   = 32'(segs) - 32'd1;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_single = r_single;
        n_count  = r_count;
        n_size   = r_size;
        n_warn   = r_warn;
        n_quo    = r_quo;
        n_rem    = r_rem;
        unique case (r_state)
            icf_pkg::DRV_IDLE: begin
                if (i_cfg_fire) begin
                    n_len = i_cfg_len;
                    if (i_cfg_len <= 31'(icf_pkg::FIRST_SEG_BYTES)) begin
                        n_single = 1'b1;
                        n_count  = '0;
                        n_warn   = 1'b0;
                        n_size   = {1'b0, i_cfg_len} - icf_pkg::PROFILE_BYTES;
                    end else begin
                        n_single = 1'b0;
                        n_state  = icf_pkg::DRV_FOLD;
                    end
                end
            end
            icf_pkg::DRV_FOLD: begin
                n_quo   = {1'b0, data_hi};
                n_rem   = fold1;
                n_state = icf_pkg::DRV_REFOLD;
            end
            icf_pkg::DRV_REFOLD: begin
                // second fold leaves less than twice the payload: one trim
                n_quo   = r_quo + {11'd0, rem_hi} + {15'd0, fold2_ge};
                n_rem   = {4'd0, (fold2_ge ? fold2_sub : fold2)};
                n_state = icf_pkg::DRV_FIN;
            end
            icf_pkg::DRV_FIN: begin
                // quotient stays below 2^16 for a 31-bit length
                n_count = r_quo;
                n_size  = {1'b0, r_len} + (segs_m1 << 4) + (segs_m1 << 1)
                          - icf_pkg::PROFILE_BYTES;
                n_warn  = (segs >= icf_pkg::WARN_SEGMENTS) && (n_data[30:24] == 7'd0);
                n_state = icf_pkg::DRV_IDLE;
            end
            default: begin
                n_state = icf_pkg::DRV_IDLE;
            end
        endcase
    end

    assign o_drv.len        = r_len;
    assign o_drv.single     = r_single;
    assign o_drv.seg_count  = r_count;
    assign o_drv.size_field = r_size;
    assign o_drv.warn       = r_warn;
    assign o_drv.busy       = (r_state != icf_pkg::DRV_IDLE);

endmodule

FILE: rtl/icc_app2_segment_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_app2_segment_framer
// Frames an ICC profile byte stream into APP2 ICC_PROFILE segments.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one raw byte a beat; the output
// channel (o_out_valid / i_out_ready) gives one framed byte a beat with its
// last-byte and warning flags. The config channel writes the stream length and
// restarts the stream; o_in_ready stays low while a config beat is offered.
// A byte goes first into the byte buffer and then into the output register; a
// stalled receiver or a pending header can hold it in the buffer.
// Throughput: one byte a cycle while the receiver keeps up and no header is
// due; a beat that opens a later segment yields its 18 header bytes first,
// during which the input is held off once the byte buffer is full.
// A length write that needs more than one segment starts a fold-and-trim
// division by the payload size: while it runs through its fold, refold and
// finish states neither input nor config beats are taken. Reset leaves a
// length of 1024 in single-segment mode with nothing pending.
// A stalled receiver holds the output register; one further input beat is
// buffered, after which o_in_ready drops until the output drains.
// ----------------------------------------------------------------------------
module icc_app2_segment_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [icf_pkg::LEN_W-1:0]     i_cfg_total_length,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_data_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_last_byte,
    output logic                          o_segment_warning
);

    icf_pkg::t_derived drv;

    logic cfg_fire;
    logic in_fire;

    assign o_cfg_ready = !drv.busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    icf_derive u_derive (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_fire (cfg_fire),
        .i_cfg_len  (i_cfg_total_length),
        .o_drv      (drv)
    );

    // stream position
    logic [icf_pkg::LEN_W-1:0] r_pos, n_pos;
    logic [16:0]               r_bis, n_bis;
    logic [15:0]               r_segnum, n_segnum;

    // byte buffer
    logic        r_a_valid, n_a_valid;
    logic        r_a_hdr, n_a_hdr;
    logic [4:0]  r_a_idx, n_a_idx;
    logic [15:0] r_a_seglen, n_a_seglen;
    logic [15:0] r_a_segnum, n_a_segnum;
    logic [7:0]  r_a_byte, n_a_byte;
    logic        r_a_last, n_a_last;

    // output register
    logic        r_o_valid, n_o_valid;
    logic [7:0]  r_o_byte, n_o_byte;
    logic        r_o_last, n_o_last;
    logic        r_o_warn, n_o_warn;

    logic                      b_load;
    logic                      a_free;
    logic                      len_zero;
    logic                      need_hdr;
    logic                      is_last;
    logic                      in_first;
    logic [icf_pkg::LEN_W-1:0] left;
    logic [16:0]               seg_bytes;
    logic [15:0]               seglen;
    logic [15:0]               len_m22;
    logic [15:0]               len_m38;
    logic [7:0]                patched;
    logic [16:0]               bis_inc;
    logic [16:0]               bis_limit;

    assign b_load     = r_a_valid && (!r_o_valid || i_out_ready);
    assign a_free     = b_load && !r_a_hdr;
    assign o_in_ready = !drv.busy && !i_cfg_valid && (!r_a_valid || a_free);
    assign in_fire    = i_in_valid && o_in_ready;

    assign len_zero  = (drv.len == '0);
    assign in_first  = r_pos < 31'(icf_pkg::FIRST_SEG_BYTES);
    assign need_hdr  = !drv.single && !in_first && (r_bis == 17'd0);
    assign is_last   = (r_pos == drv.len - 31'd1);
    assign left      = drv.len - r_pos;
    assign seg_bytes = (left < 31'(icf_pkg::SEGMENT_PAYLOAD)) ? left[16:0]
                                                              : icf_pkg::SEGMENT_PAYLOAD;
    assign seglen    = seg_bytes[15:0] + icf_pkg::SEG_LEN_EXTRA;
    assign len_m22   = drv.len[15:0] - 16'd22;
    assign len_m38   = drv.len[15:0] - 16'd38;
    assign bis_inc   = r_bis + 17'd1;
    assign bis_limit = in_first ? icf_pkg::FIRST_SEG_BYTES : icf_pkg::SEGMENT_PAYLOAD;

    // patched byte at the current position
    always_comb begin
        patched = i_data_byte;
        priority if (r_pos == icf_pkg::POS_SIZE_B3) begin
            patched = drv.size_field[31:24];
        end else if (r_pos == icf_pkg::POS_SIZE_B2) begin
            patched = drv.size_field[23:16];
        end else if (r_pos == icf_pkg::POS_SIZE_B1) begin
            patched = drv.size_field[15:8];
        end else if (r_pos == icf_pkg::POS_SIZE_B0) begin
            patched = drv.size_field[7:0];
        end else if (drv.single && r_pos == icf_pkg::POS_SEG_HI) begin
            patched = len_m22[15:8];
        end else if (drv.single && r_pos == icf_pkg::POS_SEG_LO) begin
            patched = len_m22[7:0];
        end else if (drv.single && r_pos == icf_pkg::POS_TOTAL) begin
            patched = 8'd1;
        end else if (drv.single && r_pos == icf_pkg::POS_PROF_HI) begin
            patched = len_m38[15:8];
        end else if (drv.single && r_pos == icf_pkg::POS_PROF_LO) begin
            patched = len_m38[7:0];
        end else if (!drv.single && r_pos == icf_pkg::POS_CNT_HI) begin
            patched = drv.seg_count[15:8];
        end else if (!drv.single && r_pos == icf_pkg::POS_CNT_LO) begin
            patched = drv.seg_count[7:0];
        end else begin
            patched = i_data_byte;
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_bis      = r_bis;
        n_segnum   = r_segnum;
        n_a_valid  = r_a_valid;
        n_a_hdr    = r_a_hdr;
        n_a_idx    = r_a_idx;
        n_a_seglen = r_a_seglen;
        n_a_segnum = r_a_segnum;
        n_a_byte   = r_a_byte;
        n_a_last   = r_a_last;
        n_o_valid  = r_o_valid;
        n_o_byte   = r_o_byte;
        n_o_last   = r_o_last;
        n_o_warn   = r_o_warn;

        // output register: header bytes first, then the data byte
        if (b_load) begin
            n_o_valid = 1'b1;
            n_o_warn  = drv.warn;
            if (r_a_hdr) begin
                n_o_byte = icf_pkg::hdr_byte(r_a_idx, r_a_seglen, r_a_segnum);
                n_o_last = 1'b0;
                n_a_idx  = r_a_idx + 5'd1;
                if (r_a_idx == icf_pkg::HDR_LAST_IDX) begin
                    n_a_hdr = 1'b0;
                end
            end else begin
                n_o_byte  = r_a_byte;
                n_o_last  = r_a_last;
                n_a_valid = 1'b0;
            end
        end else if (i_out_ready) begin
            n_o_valid = 1'b0;
        end

        if (cfg_fire) begin
            n_pos    = '0;
            n_bis    = '0;
            n_segnum = 16'd1;
        end else if (in_fire && !len_zero) begin
            n_a_valid  = 1'b1;
            n_a_hdr    = need_hdr;
            n_a_idx    = '0;
            n_a_seglen = seglen;
            n_a_segnum = r_segnum;
            n_a_byte   = patched;
            n_a_last   = is_last;
            if (is_last) begin
                n_pos    = '0;
                n_bis    = '0;
                n_segnum = 16'd1;
            end else begin
                n_pos = r_pos + 31'd1;
                if (!drv.single) begin
                    if (bis_inc >= bis_limit) begin
                        n_bis    = '0;
                        n_segnum = r_segnum + 16'd1;
                    end else begin
                        n_bis = bis_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_bis     <= '0;
            r_segnum  <= 16'd1;
            r_a_valid <= 1'b0;
            r_a_hdr   <= 1'b0;
            r_a_idx   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_bis     <= n_bis;
            r_segnum  <= n_segnum;
            r_a_valid <= n_a_valid;
            r_a_hdr   <= n_a_hdr;
            r_a_idx   <= n_a_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_seglen <= n_a_seglen;
        r_a_segnum <= n_a_segnum;
        r_a_byte   <= n_a_byte;
        r_a_last   <= n_a_last;
        r_o_byte   <= n_o_byte;
        r_o_last   <= n_o_last;
        r_o_warn   <= n_o_warn;
    end

    assign o_out_valid       = r_o_valid;
    assign o_out_byte        = r_o_byte;
    assign o_last_byte       = r_o_last;
    assign o_segment_warning = r_o_warn;

    // no beats taken while the divider runs
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drv.busy |-> (!o_in_ready && !o_cfg_ready))
        else $error("beat accepted while derive unit busy");

    // the final byte of a stream rewinds the position
    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !len_zero && is_last) |=> (r_pos == '0 && r_segnum == 16'd1))
        else $error("stream position not rewound after last byte");

    // header pending only on a held byte
    a_hdr_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_hdr |-> (r_a_valid && r_a_idx <= icf_pkg::HDR_LAST_IDX))
        else $error("header pending without a buffered byte");

    // segment byte count never reaches the first segment size
    a_bis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bis < icf_pkg::FIRST_SEG_BYTES)
        else $error("segment byte count out of range");

endmodule

FILE: bench/icc_app2_segment_framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_app2_segment_framer_checker
// Watches the config, input and output channels of the APP2 segment framer,
// works out the framed byte stream that each accepted input beat should give
// and compares every output beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module icc_app2_segment_framer_checker
    import icf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             o_cfg_ready,
    input  logic [LEN_W-1:0] i_cfg_total_length,
    input  logic             i_in_valid,
    input  logic             o_in_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             o_out_valid,
    input  logic             i_out_ready,
    input  logic [7:0]       o_out_byte,
    input  logic             o_last_byte,
    input  logic             o_segment_warning,
    output int               o_mismatch_count,
    output int               o_bytes_due
);

    localparam logic [31:0] WARN_LIMIT     = 32'h0100_0000;  // 16 MiB
    localparam logic [31:0] SEG_LEN_OFFSET = 32'd22;
    localparam logic [7:0]  ONE_SEGMENT    = 8'h01;

    // later-segment header: FF E2, length, "ICC_PROFILE", sequence number, FF
    localparam logic [8*HEADER_BYTES-1:0] SEG_HEADER =
        144'hFFE2FFFF_4943435F_50524F46_494C45_0000FF;
    localparam int HDR_LEN_HI = 2;
    localparam int HDR_LEN_LO = 3;
    localparam int HDR_NUM_HI = 15;
    localparam int HDR_NUM_LO = 16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic       segment_warning;
    } t_framed;

    t_framed     framed_due[$];

    logic [30:0] stream_len;
    logic [31:0] stream_pos;
    logic [16:0] seg_fill;
    logic [15:0] seg_num;
    logic [31:0] full_segs;
    logic [31:0] size_word;
    logic        single_seg;
    logic        warn_flag;

    // segment layout follows from the length alone; a new length restarts the stream
    function automatic void set_length(input logic [30:0] len);
        logic [31:0] len32;
        logic [31:0] n;
        logic [31:0] rem;
        logic [31:0] segs;
        len32      = {1'b0, len};
        stream_len = len;
        single_seg = len32 <= 32'(FIRST_SEG_BYTES);
        warn_flag  = 1'b0;
        if (single_seg) begin
            full_segs = '0;
            size_word = len32 - PROFILE_BYTES;
        end else begin
            n         = len32 - 32'(FIRST_EXTRA);
            full_segs = n / 32'(SEGMENT_PAYLOAD);
            rem       = n % 32'(SEGMENT_PAYLOAD);
            segs      = full_segs + ((rem != 0) ? 32'd1 : 32'd0);
            size_word = len32 + 32'(HEADER_BYTES) * (segs - 32'd1) - PROFILE_BYTES;
            warn_flag = (segs >= 32'(WARN_SEGMENTS)) && (n < WARN_LIMIT);
        end
        stream_pos = '0;
        seg_fill   = '0;
        seg_num    = 16'd1;
    endfunction

    function automatic logic [7:0] patched_byte(input logic [31:0] p, input logic [7:0] d);
        logic [31:0] seg_sz;
        logic [31:0] prof_sz;
        seg_sz  = {1'b0, stream_len} - SEG_LEN_OFFSET;
        prof_sz = {1'b0, stream_len} - 32'(FIRST_EXTRA);
        case (p)
            32'(POS_SIZE_B3): return size_word[31:24];
            32'(POS_SIZE_B2): return size_word[23:16];
            32'(POS_SIZE_B1): return size_word[15:8];
            32'(POS_SIZE_B0): return size_word[7:0];
            default: ;
        endcase
        if (single_seg) begin
            case (p)
                32'(POS_SEG_HI):  return seg_sz[15:8];
                32'(POS_SEG_LO):  return seg_sz[7:0];
                32'(POS_TOTAL):   return ONE_SEGMENT;
                32'(POS_PROF_HI): return prof_sz[15:8];
                32'(POS_PROF_LO): return prof_sz[7:0];
                default: ;
            endcase
        end else begin
            case (p)
                32'(POS_CNT_HI): return full_segs[15:8];
                32'(POS_CNT_LO): return full_segs[7:0];
                default: ;
            endcase
        end
        return d;
    endfunction

    function automatic void frame_input(input logic [7:0] d);
        logic [31:0] len32;
        logic [31:0] p;
        logic [31:0] left;
        logic [31:0] seg_len;
        logic [31:0] lim;
        logic [7:0]  v;
        logic        is_last;
        len32 = {1'b0, stream_len};
        p     = stream_pos;
        if (p >= len32)
            return;  // zero length: byte swallowed

        if (!single_seg && p >= 32'(FIRST_SEG_BYTES) && seg_fill == '0) begin
            left    = len32 - p;
            seg_len = ((left < 32'(SEGMENT_PAYLOAD)) ? left : 32'(SEGMENT_PAYLOAD))
                      + 32'(SEG_LEN_EXTRA);
            for (int i = 0; i < HEADER_BYTES; i++) begin
                v = SEG_HEADER[8*(HEADER_BYTES-1-i) +: 8];
                if (i == HDR_LEN_HI) v = seg_len[15:8];
                if (i == HDR_LEN_LO) v = seg_len[7:0];
                if (i == HDR_NUM_HI) v = seg_num[15:8];
                if (i == HDR_NUM_LO) v = seg_num[7:0];
                framed_due.push_back('{v, 1'b0, warn_flag});
            end
        end

        is_last = (p == len32 - 32'd1);
        framed_due.push_back('{patched_byte(p, d), is_last, warn_flag});

        if (is_last) begin
            stream_pos = '0;
            seg_fill   = '0;
            seg_num    = 16'd1;
            return;
        end

        stream_pos = p + 32'd1;
        if (!single_seg) begin
            lim      = (p < 32'(FIRST_SEG_BYTES)) ? 32'(FIRST_SEG_BYTES)
                                                  : 32'(SEGMENT_PAYLOAD);
            seg_fill = seg_fill + 17'd1;
            if (32'(seg_fill) >= lim) begin
                seg_fill = '0;
                seg_num  = seg_num + 16'd1;
            end
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_framed want;
        if (!i_rst_n) begin
            set_length(RESET_LENGTH);
            framed_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                set_length(i_cfg_total_length);
            if (i_in_valid && o_in_ready)
                frame_input(i_data_byte);
            if (o_out_valid && i_out_ready) begin
                if (framed_due.size() == 0) begin
                    $error("output beat with nothing due: out_byte 0x%02h", o_out_byte);
                    o_mismatch_count++;
                end else begin
                    want = framed_due.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h",
                               want.out_byte, o_out_byte);
                        o_mismatch_count++;
                    end
                    if (o_last_byte !== want.last_byte) begin
                        $error("last_byte: expected %0b, got %0b",
                               want.last_byte, o_last_byte);
                        o_mismatch_count++;
                    end
                    if (o_segment_warning !== want.segment_warning) begin
                        $error("segment_warning: expected %0b, got %0b",
                               want.segment_warning, o_segment_warning);
                        o_mismatch_count++;
                    end
                end
            end
        end
        o_bytes_due = framed_due.size();
    end

endmodule

FILE: bench/icc_app2_segment_framer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icc_app2_segment_framer_test
// Drives length writes and raw byte streams into the APP2 segment framer under
// random idling on both sides, with a long output hold-off to back the block
// up; the checker beside the block compares every framed byte.
// ----------------------------------------------------------------------------
module icc_app2_segment_framer_test;

    import icf_pkg::*;

    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AT_BEAT  = 25;      // lands inside the short-stream phase
    localparam int HOLD_SPACING  = 100000;

    localparam logic [63:0] EDGE_BYTES = 64'h00FF_55AA_0180_7FFE;

    localparam logic [30:0] LEN_ZERO        = 31'd0;
    localparam logic [30:0] LEN_ONE         = 31'd1;
    localparam logic [30:0] LEN_SHORT       = 31'd45;
    localparam logic [30:0] LEN_SINGLE_MAX  = 31'd65557;
    localparam logic [30:0] LEN_MULTI_MIN   = 31'd65558;
    localparam logic [30:0] LEN_TWO_FULL    = 31'd131076;
    localparam logic [30:0] LEN_WARN_EXACT  = 31'd6551938;
    localparam logic [30:0] LEN_NO_WARN     = 31'd6486419;
    localparam logic [30:0] LEN_WARN_FIRST  = 31'd6486420;
    localparam logic [30:0] LEN_AT_LIMIT    = 31'd16777254;
    localparam logic [30:0] LEN_BELOW_LIMIT = 31'd16777253;
    localparam logic [30:0] LEN_MAX         = 31'h7FFF_FFFF;

    typedef enum int {
        PACE_NONE,
        PACE_SPARSE,
        PACE_BUSY
    } t_pace;

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_cfg_valid        = 1'b0;
    logic [LEN_W-1:0] i_cfg_total_length = '0;
    logic             i_in_valid         = 1'b0;
    logic [7:0]       i_data_byte        = '0;
    logic             i_out_ready        = 1'b0;

    logic             o_cfg_ready;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [7:0]       o_out_byte;
    logic             o_last_byte;
    logic             o_segment_warning;

    int               mismatch_count;
    int               bytes_due;

    t_pace            tx_pace = PACE_BUSY;
    t_pace            rx_pace = PACE_BUSY;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    icc_app2_segment_framer DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_total_length (i_cfg_total_length),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_last_byte        (o_last_byte),
        .o_segment_warning  (o_segment_warning)
    );

    icc_app2_segment_framer_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_total_length (i_cfg_total_length),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_byte         (o_out_byte),
        .o_last_byte        (o_last_byte),
        .o_segment_warning  (o_segment_warning),
        .o_mismatch_count   (mismatch_count),
        .o_bytes_due        (bytes_due)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_cycles(input t_pace pace);
        int r;
        case (pace)
            PACE_NONE:   return 0;
            PACE_SPARSE: begin
                r = $urandom_range(0, 1023);
                if (r < 8)
                    return $urandom_range(1, 8);
                if (r == 8)
                    return $urandom_range(30, 80);
                return 0;
            end
            default: begin
                r = $urandom_range(0, 99);
                if (r < 55)
                    return 0;
                if (r < 90)
                    return $urandom_range(1, 3);
                if (r < 97)
                    return $urandom_range(4, 12);
                return $urandom_range(20, 60);
            end
        endcase
    endfunction

    task automatic offer_byte(input logic [7:0] b);
        int gap;
        gap = idle_cycles(tx_pace);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic feed_random(input int count);
        for (int i = 0; i < count; i++)
            offer_byte(8'($urandom_range(0, 255)));
    endtask

    // wait until every byte due has come out, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (bytes_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_length(input logic [30:0] len);
        i_cfg_valid        <= 1'b1;
        i_cfg_total_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [30:0] len, input int count);
        tx_pace = t_pace'($urandom_range(0, 2));
        rx_pace = t_pace'($urandom_range(0, 2));
        program_length(len);
        feed_random(count);
        settle();
    endtask

    // output side: random stalls plus a long hold-off every so often
    initial begin : out_side
        int beats;
        int stall;
        int squeeze_at;
        beats      = 0;
        squeeze_at = HOLD_AT_BEAT;
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid)
                beats++;
            if (beats >= squeeze_at) begin
                stall      = LONG_HOLD;
                squeeze_at = squeeze_at + HOLD_SPACING;
            end else begin
                stall = idle_cycles(rx_pace);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    initial begin : stimulus
        logic [30:0] len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length, single segment
        for (int i = 0; i < 8; i++)
            offer_byte(EDGE_BYTES[8*(7-i) +: 8]);
        feed_random(4);
        settle();

        run_phase(LEN_ZERO, 3);          // every byte swallowed
        run_phase(LEN_ONE, 3);           // each byte is the last
        run_phase(LEN_SHORT, 50);        // patched fields, then a fresh stream
        run_phase(LEN_SINGLE_MAX, 3);
        run_phase(LEN_MULTI_MIN, 3);
        run_phase(LEN_TWO_FULL, 3);
        run_phase(LEN_WARN_EXACT, 3);
        run_phase(LEN_NO_WARN, 3);
        run_phase(LEN_WARN_FIRST, 3);
        run_phase(LEN_AT_LIMIT, 3);
        run_phase(LEN_BELOW_LIMIT, 3);
        run_phase(LEN_MAX, 3);

        // random lengths, mostly short so that streams wrap and restart
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 3))
                0:       len = 31'($urandom_range(1, 64));
                1:       len = 31'($urandom_range(65, 700));
                2:       len = 31'($urandom);
                default: len = 31'($urandom_range(1, 8));
            endcase
            run_phase(len, $urandom_range(2, 4));
        end
        run_phase(RESET_LENGTH, 4);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatch_count == 0 && bytes_due == 0) begin
            $display("icc_app2_segment_framer regression: pass");
        end else begin
            $display("icc_app2_segment_framer regression: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("icc_app2_segment_framer regression: fail");
        $finish;
    end

endmodule
